/* hdl/edep_pkg.sv */
`default_nettype none

package edep_pkg;

    // input kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    localparam int TIME_BITS    = 64;
    localparam int OUT_PAY_BITS = 32;

    // one finished result, handed from the sequencer to the output register
    typedef struct packed {
        logic [1:0]                     status;
        logic signed [TIME_BITS-1:0]    popped_time;
        logic [OUT_PAY_BITS-1:0]        popped_payload;
        logic signed [TIME_BITS-1:0]    next_due_time;
        logic                           pool_empty;
    } res_t;

endpackage

`default_nettype wire

/* hdl/edep_slot_mem.sv */
`default_nettype none

module edep_slot_mem #(
    parameter int SLOTS  = 16,
    parameter int PW     = 32,
    parameter int IW     = 4
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [IW-1:0]                wr_addr,
    input  wire logic signed [edep_pkg::TIME_BITS-1:0] wr_time,
    input  wire logic [PW-1:0]                wr_payload,
    input  wire logic                         rd_en,
    input  wire logic [IW-1:0]                rd_addr,
    output logic signed [edep_pkg::TIME_BITS-1:0]      rd_time,
    output logic [PW-1:0]                     rd_payload
);
    import edep_pkg::*;

    // time and payload share one word per slot
    logic [TIME_BITS+PW-1:0] mem [SLOTS];
    logic [TIME_BITS+PW-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_time, wr_payload};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_time    = $signed(rd_word_reg[TIME_BITS+PW-1:PW]);
    assign rd_payload = rd_word_reg[PW-1:0];

endmodule

`default_nettype wire

/* hdl/edep_ctrl.sv */
`default_nettype none

module edep_ctrl #(
    parameter int SLOTS  = 16,
    parameter int PW     = 32,
    parameter int IW     = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         kind,
    input  wire logic signed [edep_pkg::TIME_BITS-1:0] event_time,
    input  wire logic [edep_pkg::OUT_PAY_BITS-1:0]     event_payload,
    // slot memory
    output logic                              wr_en,
    output logic [IW-1:0]                     wr_addr,
    output logic signed [edep_pkg::TIME_BITS-1:0]      wr_time,
    output logic [PW-1:0]                     wr_payload,
    output logic                              rd_en,
    output logic [IW-1:0]                     rd_addr,
    input  wire logic signed [edep_pkg::TIME_BITS-1:0] rd_time,
    input  wire logic [PW-1:0]                rd_payload,
    // result towards the output register
    output logic                              res_valid,
    output edep_pkg::res_t                    res,
    input  wire logic                         res_take
);
    import edep_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_POP_RD,
        S_SCAN,
        S_SCAN_END,
        S_RESULT
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    state_t                     state_reg;
    logic [IW-1:0]              idx_reg;
    logic [SLOTS-1:0]           valid_reg;
    logic                       ev_reg;
    logic [IW-1:0]              eslot_reg;
    logic signed [TIME_BITS-1:0] etime_reg;
    logic signed [TIME_BITS-1:0] time_reg;
    logic [PW-1:0]              pay_reg;
    logic [1:0]                 status_reg;
    logic signed [TIME_BITS-1:0] ptime_reg;
    logic [PW-1:0]              ppay_reg;
    // compare stage of the scan, registered behind the read issue
    logic                       chk_live_reg;
    logic                       chk_valid_reg;
    logic [IW-1:0]              chk_idx_reg;

    logic                       accept;
    logic                       slot_free;
    logic                       chk_hit;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !valid_reg[idx_reg];
    assign chk_hit   = chk_live_reg && chk_valid_reg && (!ev_reg || (rd_time < etime_reg));

    assign wr_en      = (state_reg == S_FIND) && slot_free;
    assign wr_addr    = idx_reg;
    assign wr_time    = time_reg;
    assign wr_payload = pay_reg;

    assign rd_en   = (accept && (kind == KIND_POP)) || (state_reg == S_SCAN);
    assign rd_addr = (state_reg == S_SCAN) ? idx_reg : eslot_reg;

    assign res_valid          = (state_reg == S_RESULT);
    assign res.status         = status_reg;
    assign res.popped_time    = ptime_reg;
    assign res.popped_payload = OUT_PAY_BITS'(ppay_reg);
    assign res.next_due_time  = ev_reg ? etime_reg : '0;
    assign res.pool_empty     = !ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            ev_reg        <= 1'b0;
            eslot_reg     <= '0;
            etime_reg     <= '0;
            status_reg    <= ST_OK;
            ptime_reg     <= '0;
            ppay_reg      <= '0;
            chk_live_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            time_reg      <= '0;
            pay_reg       <= '0;
        end
        else
        begin
            chk_live_reg  <= (state_reg == S_SCAN);
            chk_valid_reg <= valid_reg[idx_reg];
            chk_idx_reg   <= idx_reg;

            if (chk_hit)
            begin
                ev_reg    <= 1'b1;
                eslot_reg <= chk_idx_reg;
                etime_reg <= rd_time;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        time_reg  <= event_time;
                        pay_reg   <= event_payload[PW-1:0];
                        idx_reg   <= '0;
                        ptime_reg <= '0;
                        ppay_reg  <= '0;
                        if (kind == KIND_PUSH)
                        begin
                            state_reg <= S_FIND;
                        end
                        else if (!ev_reg)
                        begin
                            status_reg <= ST_POP_EMPTY;
                            state_reg  <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_POP_RD;
                        end
                    end
                end
                S_FIND:
                begin
                    if (slot_free)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        // strictly earlier only: on a tie the older entry stays
                        if (!ev_reg || (time_reg < etime_reg))
                        begin
                            ev_reg    <= 1'b1;
                            eslot_reg <= idx_reg;
                            etime_reg <= time_reg;
                        end
                        status_reg <= ST_OK;
                        state_reg  <= S_RESULT;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        status_reg <= ST_PUSH_FULL;
                        state_reg  <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_POP_RD:
                begin
                    ptime_reg            <= rd_time;
                    ppay_reg             <= rd_payload;
                    valid_reg[eslot_reg] <= 1'b0;
                    ev_reg               <= 1'b0;
                    eslot_reg            <= '0;
                    etime_reg            <= '0;
                    status_reg           <= ST_OK;
                    idx_reg              <= '0;
                    state_reg            <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_SCAN_END;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN_END:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/earliest_deadline_event_pool.sv */
// earliest-deadline event pool: SLOTS timed events, each a signed 64-bit
// time and an opaque payload, kept in a single-port-read slot memory
//
// input channel (in_valid / in_stall): one transfer carries kind, event_time
// and event_payload. a push stores the event in the lowest free slot; a pop
// returns the pending event with the earliest time and frees its slot
// output channel (out_valid / out_stall): exactly one result transfer per
// input transfer, in order: status, popped fields, next_due_time, pool_empty
//
// a push walks the valid bits from slot 0 to the first free one. a pop
// rescans every slot through the memory read port, one slot per cycle
// with a registered read; a refused pop goes straight to its result.
// one item is worked on at a time; the next input transfer is taken once
// the result has moved into the output register
//
// reset clears all valid bits and the earliest-event tracking, so the pool
// starts empty; slot contents need no clearing. a full output register holds
// its result while out_stall is high; the sequencer then holds in_stall high
`default_nettype none

module earliest_deadline_event_pool #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         kind,
    input  wire logic signed [edep_pkg::TIME_BITS-1:0] event_time,
    input  wire logic [edep_pkg::OUT_PAY_BITS-1:0]     event_payload,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        status,
    output logic signed [edep_pkg::TIME_BITS-1:0]      popped_time,
    output logic [edep_pkg::OUT_PAY_BITS-1:0]          popped_payload,
    output logic signed [edep_pkg::TIME_BITS-1:0]      next_due_time,
    output logic                              pool_empty
);
    import edep_pkg::*;

    // stored payload width: the port only carries 32 bits
    localparam int PW = (PAYLOAD_BITS < OUT_PAY_BITS) ? PAYLOAD_BITS : OUT_PAY_BITS;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic signed [TIME_BITS-1:0] wr_time;
    logic [PW-1:0]               wr_payload;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic signed [TIME_BITS-1:0] rd_time;
    logic [PW-1:0]               rd_payload;

    logic                        res_valid;
    res_t                        res;
    logic                        res_take;

    logic                        out_valid_reg;
    res_t                        out_reg;

    edep_slot_mem #(
        .SLOTS (SLOTS),
        .PW    (PW),
        .IW    (IW)
    ) u_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_time    (wr_time),
        .wr_payload (wr_payload),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_time    (rd_time),
        .rd_payload (rd_payload)
    );

    edep_ctrl #(
        .SLOTS (SLOTS),
        .PW    (PW),
        .IW    (IW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .event_time    (event_time),
        .event_payload (event_payload),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_time       (wr_time),
        .wr_payload    (wr_payload),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_time       (rd_time),
        .rd_payload    (rd_payload),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    // the output register is free when empty or when its result leaves now
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload register, loaded only on a new result so a stalled one holds
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign popped_time    = out_reg.popped_time;
    assign popped_payload = out_reg.popped_payload;
    assign next_due_time  = out_reg.next_due_time;
    assign pool_empty     = out_reg.pool_empty;

endmodule

`default_nettype wire
